/* rtl/core/mt64_pkg.sv */
`timescale 1ns / 1ps

package mt64_pkg;

    localparam int STATE_WORDS  = 312;
    localparam int SHIFT_OFFSET = 156;
    localparam int POS_W        = 9;

    localparam logic [63:0] TWIST_MATRIX  = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] UPPER_MASK    = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] LOWER_MASK    = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] MUL_SEED      = 64'd6364136223846793005;
    localparam logic [63:0] MUL_KEY_A     = 64'd3935559000370003845;
    localparam logic [63:0] MUL_KEY_B     = 64'd2862933555777941757;
    localparam logic [63:0] KEY_BASE_SEED = 64'd19650218;
    localparam logic [63:0] DEFAULT_SEED  = 64'd5489;
    localparam logic [63:0] TEMPER_U      = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TEMPER_B      = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TEMPER_C      = 64'hFFF7_EEE0_0000_0000;
    localparam logic [63:0] KEY_TOP_WORD  = 64'h8000_0000_0000_0000;

    localparam logic [1:0] OP_SEED     = 2'd0;
    localparam logic [1:0] OP_DRAW     = 2'd1;
    localparam logic [1:0] OP_KEY_LOAD = 2'd2;
    localparam logic [1:0] OP_KEY_SEED = 2'd3;

    localparam logic [7:0] CFG_KEY_LENGTH  = 8'd0;
    localparam logic [7:0] CFG_OUTPUT_MODE = 8'd1;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_SEED,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_SV_WR,
        DP_K_INIT,
        DP_K1_WR,
        DP_K2_INIT,
        DP_K2_WR,
        DP_WRAP,
        DP_K_FINAL,
        DP_R_INIT,
        DP_R_RD,
        DP_R_X,
        DP_R_WR,
        DP_D_RD,
        DP_D_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        PH_SV,
        PH_K1,
        PH_K2
    } t_phase;

    typedef enum logic [1:0] {
        SRC_USER,
        SRC_KEYBASE,
        SRC_DEFAULT
    } t_seed_src;

    typedef struct packed {
        t_dp_op    op;
        t_phase    phase;
        t_seed_src src;
    } t_dp_cmd;

    typedef struct packed {
        logic i_last;
        logic cnt_one;
        logic cnt_zero;
        logic pos_end;
        logic out_free;
    } t_dp_st;

endpackage

/* rtl/core/mt19937_64_generator.sv */
`timescale 1ns / 1ps
// Draw: the word is read (D_RD), then tempered into the output register (D_OUT), which
// waits while the output stalls; after every 312 draws a regeneration pass comes first.
// Seed from value: per word MUL0, MUL1, MUL2 and a write, on one shared 32x32 multiplier.
// Seed from key: value seeding, then two mixing passes.
// Key load leaves the block idle; config is always ready. Reset: synchronous; the block
// then seeds itself with 5489 before accepting a request. Key store undefined until loaded.
module mt19937_64_generator #(
    parameter int KEY_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_seed_value,
    input  logic [3:0]  i_key_index,
    input  logic [63:0] i_key_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_random_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    mt64_pkg::t_dp_cmd cmd;
    mt64_pkg::t_dp_st  st;

    assign o_cfg_ready = 1'b1;

    mt64_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_st        (st),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    mt64_datapath #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_operation    (i_operation),
        .i_seed_value   (i_seed_value),
        .i_key_index    (i_key_index),
        .i_key_word     (i_key_word),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_random_value (o_random_value)
    );

endmodule

/* rtl/core/mt64_ctrl.sv */
`timescale 1ns / 1ps

module mt64_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_operation,
    input  mt64_pkg::t_dp_st   i_st,
    output logic               o_in_stall,
    output mt64_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_SEED, S_MUL0, S_MUL1, S_MUL2, S_SV_WR,
        S_K_INIT, S_K1_WR, S_K1_WRAP, S_K2_INIT, S_K2_WR, S_K2_WRAP, S_K_FINAL,
        S_R_INIT, S_R_RD, S_R_X, S_R_WR, S_D_RD, S_D_OUT
    } t_state;

    t_state              r_state;
    mt64_pkg::t_phase    r_phase;
    mt64_pkg::t_seed_src r_src;
    logic                r_to_key;
    logic                accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd.phase = r_phase;
        o_cmd.src   = r_src;
        unique case (r_state)
            S_IDLE:    o_cmd.op = accept ? mt64_pkg::DP_CAPTURE : mt64_pkg::DP_NOP;
            S_SEED:    o_cmd.op = mt64_pkg::DP_SEED;
            S_MUL0:    o_cmd.op = mt64_pkg::DP_MUL0;
            S_MUL1:    o_cmd.op = mt64_pkg::DP_MUL1;
            S_MUL2:    o_cmd.op = mt64_pkg::DP_MUL2;
            S_SV_WR:   o_cmd.op = mt64_pkg::DP_SV_WR;
            S_K_INIT:  o_cmd.op = mt64_pkg::DP_K_INIT;
            S_K1_WR:   o_cmd.op = mt64_pkg::DP_K1_WR;
            S_K1_WRAP: o_cmd.op = mt64_pkg::DP_WRAP;
            S_K2_INIT: o_cmd.op = mt64_pkg::DP_K2_INIT;
            S_K2_WR:   o_cmd.op = mt64_pkg::DP_K2_WR;
            S_K2_WRAP: o_cmd.op = mt64_pkg::DP_WRAP;
            S_K_FINAL: o_cmd.op = mt64_pkg::DP_K_FINAL;
            S_R_INIT:  o_cmd.op = mt64_pkg::DP_R_INIT;
            S_R_RD:    o_cmd.op = mt64_pkg::DP_R_RD;
            S_R_X:     o_cmd.op = mt64_pkg::DP_R_X;
            S_R_WR:    o_cmd.op = mt64_pkg::DP_R_WR;
            S_D_RD:    o_cmd.op = mt64_pkg::DP_D_RD;
            S_D_OUT:   o_cmd.op = mt64_pkg::DP_D_OUT;
            default:   o_cmd.op = mt64_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SEED;
            r_phase  <= mt64_pkg::PH_SV;
            r_src    <= mt64_pkg::SRC_DEFAULT;
            r_to_key <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_operation)
                            mt64_pkg::OP_SEED: begin
                                r_src    <= mt64_pkg::SRC_USER;
                                r_to_key <= 1'b0;
                                r_state  <= S_SEED;
                            end
                            mt64_pkg::OP_KEY_SEED: begin
                                r_src    <= mt64_pkg::SRC_KEYBASE;
                                r_to_key <= 1'b1;
                                r_state  <= S_SEED;
                            end
                            mt64_pkg::OP_DRAW: begin
                                r_state <= i_st.pos_end ? S_R_INIT : S_D_RD;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SEED: begin
                    r_phase <= mt64_pkg::PH_SV;
                    r_state <= S_MUL0;
                end
                S_MUL0: r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: begin
                    unique case (r_phase)
                        mt64_pkg::PH_K1: r_state <= S_K1_WR;
                        mt64_pkg::PH_K2: r_state <= S_K2_WR;
                        default:         r_state <= S_SV_WR;
                    endcase
                end
                S_SV_WR: begin
                    if (i_st.i_last) r_state <= r_to_key ? S_K_INIT : S_IDLE;
                    else r_state <= S_MUL0;
                end
                S_K_INIT: begin
                    r_phase <= mt64_pkg::PH_K1;
                    r_state <= S_MUL0;
                end
                S_K1_WR: begin
                    if (i_st.i_last) r_state <= S_K1_WRAP;
                    else if (i_st.cnt_one) r_state <= S_K2_INIT;
                    else r_state <= S_MUL0;
                end
                S_K1_WRAP: r_state <= i_st.cnt_zero ? S_K2_INIT : S_MUL0;
                S_K2_INIT: begin
                    r_phase <= mt64_pkg::PH_K2;
                    r_state <= S_MUL0;
                end
                S_K2_WR: begin
                    if (i_st.i_last) r_state <= S_K2_WRAP;
                    else if (i_st.cnt_one) r_state <= S_K_FINAL;
                    else r_state <= S_MUL0;
                end
                S_K2_WRAP: r_state <= i_st.cnt_zero ? S_K_FINAL : S_MUL0;
                S_K_FINAL: r_state <= S_IDLE;
                S_R_INIT:  r_state <= S_R_RD;
                S_R_RD:    r_state <= S_R_X;
                S_R_X:     r_state <= S_R_WR;
                S_R_WR:    r_state <= i_st.i_last ? S_D_RD : S_R_RD;
                S_D_RD:    r_state <= S_D_OUT;
                S_D_OUT: begin
                    if (i_st.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/mt64_datapath.sv */
`timescale 1ns / 1ps

module mt64_datapath #(
    parameter int KEY_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mt64_pkg::t_dp_cmd  i_cmd,
    output mt64_pkg::t_dp_st   o_st,
    input  logic [1:0]         i_operation,
    input  logic [63:0]        i_seed_value,
    input  logic [3:0]         i_key_index,
    input  logic [63:0]        i_key_word,
    input  logic               i_cfg_valid,
    input  logic [7:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [63:0]        o_random_value
);

    localparam int KI_W   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LEN_W  = $clog2(KEY_DEPTH + 1);
    localparam int CNT_MX = (KEY_DEPTH > mt64_pkg::STATE_WORDS) ? KEY_DEPTH
                                                                 : mt64_pkg::STATE_WORDS;
    localparam int CNT_W  = $clog2(CNT_MX + 1);
    localparam int PW     = mt64_pkg::POS_W;

    logic [63:0] r_mem [mt64_pkg::STATE_WORDS];
    logic [63:0] r_key_mem [KEY_DEPTH];

    logic [63:0]      r_rd_a, r_rd_b, r_key_rd;
    logic [63:0]      r_prev, r_acc, r_seed;
    logic [PW-1:0]    r_i, r_pos;
    logic [KI_W-1:0]  r_j;
    logic [CNT_W-1:0] r_cnt;
    logic [4:0]       r_key_length;
    logic             r_mode;
    logic             r_out_valid;
    logic [63:0]      r_out_value;

    logic [PW-1:0]    addr_a, addr_b, i_next, i_far, i_wrap;
    logic [PW:0]      far_sum;
    logic [LEN_W-1:0] len_eff;
    logic [63:0]      t_val, mul_c, mul_p, seed_src, wd, regen_v, ty;
    logic [31:0]      mul_a, mul_b;
    logic [PW-1:0]    wa;
    logic             we, out_free, i_last;

    assign i_last  = (r_i == PW'(mt64_pkg::STATE_WORDS - 1));
    assign i_next  = i_last ? '0 : r_i + 1'b1;
    assign i_wrap  = i_last ? PW'(1) : r_i + 1'b1;
    assign far_sum = {1'b0, r_i} + (PW+1)'(mt64_pkg::SHIFT_OFFSET);
    assign i_far   = (far_sum >= (PW+1)'(mt64_pkg::STATE_WORDS))
                   ? PW'(far_sum - (PW+1)'(mt64_pkg::STATE_WORDS)) : PW'(far_sum);

    always_comb begin
        if (r_key_length == 5'd0) len_eff = LEN_W'(1);
        else if (32'(r_key_length) > KEY_DEPTH) len_eff = LEN_W'(KEY_DEPTH);
        else len_eff = LEN_W'(r_key_length);
    end

    always_comb begin
        case (i_cmd.src)
            mt64_pkg::SRC_USER:    seed_src = r_seed;
            mt64_pkg::SRC_KEYBASE: seed_src = mt64_pkg::KEY_BASE_SEED;
            default:               seed_src = mt64_pkg::DEFAULT_SEED;
        endcase
        case (i_cmd.phase)
            mt64_pkg::PH_K1: mul_c = mt64_pkg::MUL_KEY_A;
            mt64_pkg::PH_K2: mul_c = mt64_pkg::MUL_KEY_B;
            default:         mul_c = mt64_pkg::MUL_SEED;
        endcase
    end

    // 64x64 low half from three 32x32 partial products
    assign t_val = r_prev ^ (r_prev >> 62);
    always_comb begin
        case (i_cmd.op)
            mt64_pkg::DP_MUL1: begin mul_a = t_val[63:32]; mul_b = mul_c[31:0];  end
            mt64_pkg::DP_MUL2: begin mul_a = t_val[31:0];  mul_b = mul_c[63:32]; end
            default:           begin mul_a = t_val[31:0];  mul_b = mul_c[31:0];  end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        regen_v = r_rd_a ^ (r_acc >> 1);
        if (r_acc[0]) regen_v = regen_v ^ mt64_pkg::TWIST_MATRIX;
    end

    always_comb begin
        ty = r_rd_a;
        ty = ty ^ ((ty >> 29) & mt64_pkg::TEMPER_U);
        ty = ty ^ ((ty << 17) & mt64_pkg::TEMPER_B);
        ty = ty ^ ((ty << 37) & mt64_pkg::TEMPER_C);
        ty = ty ^ (ty >> 43);
        if (r_mode) ty = ty >> 1;
    end

    always_comb begin
        case (i_cmd.op)
            mt64_pkg::DP_R_RD:  addr_a = r_i;
            mt64_pkg::DP_R_X:   addr_a = i_far;
            mt64_pkg::DP_D_RD,
            mt64_pkg::DP_D_OUT: addr_a = r_pos;
            default:            addr_a = r_i;
        endcase
        addr_b = i_next;
    end

    always_comb begin
        we = 1'b1;
        wa = r_i;
        wd = '0;
        case (i_cmd.op)
            mt64_pkg::DP_SEED:    begin wa = '0; wd = seed_src; end
            mt64_pkg::DP_SV_WR:   wd = r_acc + 64'(r_i);
            mt64_pkg::DP_K1_WR:   wd = (r_rd_a ^ r_acc) + r_key_rd + 64'(r_j);
            mt64_pkg::DP_K2_WR:   wd = (r_rd_a ^ r_acc) - 64'(r_i);
            mt64_pkg::DP_WRAP:    begin wa = '0; wd = r_prev; end
            mt64_pkg::DP_K_FINAL: begin wa = '0; wd = mt64_pkg::KEY_TOP_WORD; end
            mt64_pkg::DP_R_WR:    wd = regen_v;
            default:              we = 1'b0;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mt64_pkg::DP_CAPTURE && i_operation == mt64_pkg::OP_KEY_LOAD
                && 32'(i_key_index) < KEY_DEPTH) begin
            r_key_mem[KI_W'(i_key_index)] <= i_key_word;
        end
        r_key_rd <= r_key_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mt64_pkg::DP_CAPTURE: r_seed <= i_seed_value;
            mt64_pkg::DP_SEED: begin
                r_prev <= seed_src;
                r_i    <= PW'(1);
            end
            mt64_pkg::DP_MUL0: r_acc <= mul_p;
            mt64_pkg::DP_MUL1,
            mt64_pkg::DP_MUL2: r_acc <= r_acc + {mul_p[31:0], 32'd0};
            mt64_pkg::DP_SV_WR: begin
                r_prev <= wd;
                r_i    <= r_i + 1'b1;
            end
            mt64_pkg::DP_K_INIT: begin
                r_prev <= mt64_pkg::KEY_BASE_SEED;
                r_i    <= PW'(1);
                r_j    <= '0;
                r_cnt  <= (32'(len_eff) > mt64_pkg::STATE_WORDS) ? CNT_W'(len_eff)
                                                                 : CNT_W'(mt64_pkg::STATE_WORDS);
            end
            mt64_pkg::DP_K1_WR: begin
                r_prev <= wd;
                r_i    <= i_wrap;
                r_cnt  <= r_cnt - 1'b1;
                if (32'(r_j) + 1 >= 32'(len_eff)) r_j <= '0;
                else r_j <= r_j + 1'b1;
            end
            mt64_pkg::DP_K2_INIT: r_cnt <= CNT_W'(mt64_pkg::STATE_WORDS - 1);
            mt64_pkg::DP_K2_WR: begin
                r_prev <= wd;
                r_i    <= i_wrap;
                r_cnt  <= r_cnt - 1'b1;
            end
            mt64_pkg::DP_R_INIT: r_i <= '0;
            mt64_pkg::DP_R_X: r_acc <= (r_rd_a & mt64_pkg::UPPER_MASK)
                                     | (r_rd_b & mt64_pkg::LOWER_MASK);
            mt64_pkg::DP_R_WR: r_i <= r_i + 1'b1;
            mt64_pkg::DP_D_OUT: begin
                if (out_free) r_out_value <= ty;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= PW'(mt64_pkg::STATE_WORDS);
            r_key_length <= 5'd1;
            r_mode       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mt64_pkg::CFG_KEY_LENGTH:  r_key_length <= i_cfg_data[4:0];
                    mt64_pkg::CFG_OUTPUT_MODE: r_mode       <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                mt64_pkg::DP_SEED:  r_pos <= PW'(mt64_pkg::STATE_WORDS);
                mt64_pkg::DP_R_WR: begin
                    if (i_last) r_pos <= '0;
                end
                mt64_pkg::DP_D_OUT: begin
                    if (out_free) r_pos <= r_pos + 1'b1;
                end
                default: ;
            endcase
            if (i_cmd.op == mt64_pkg::DP_D_OUT && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_st.i_last   = i_last;
    assign o_st.cnt_one  = (r_cnt == CNT_W'(1));
    assign o_st.cnt_zero = (r_cnt == '0);
    assign o_st.pos_end  = (r_pos >= PW'(mt64_pkg::STATE_WORDS));
    assign o_st.out_free = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_value;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD   = 12;
    localparam int KEY_SLOTS    = 16;
    localparam int ITEMS_PHASE  = 300;
    localparam int SETTLE_WAIT  = 6500;
    localparam int IDLE_LIMIT   = 40000;
    localparam logic [7:0] CFG_SPARE = 8'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] seed;
        logic [3:0]  idx;
        logic [63:0] word;
        logic        known;
        logic [63:0] known_value;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [63:0] i_seed_value;
    logic [3:0]  i_key_index;
    logic [63:0] i_key_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_random_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    mt19937_64_generator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_seed_value   (i_seed_value),
        .i_key_index    (i_key_index),
        .i_key_word     (i_key_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // shadow generator state
    logic [63:0] tw_words [mt64_pkg::STATE_WORDS];
    int          tw_pos;
    logic [63:0] shadow_keys [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] keys_written;
    logic [4:0]  shadow_klen;
    logic        shadow_mode;

    logic [63:0] pending_values [$];
    int          error_count;
    int          idle_cycles;
    int          stall_left;
    bit          quiet_out;

    function automatic void seed_words(logic [63:0] seed);
        logic [63:0] p;
        tw_words[0] = seed;
        for (int n = 1; n < mt64_pkg::STATE_WORDS; n++) begin
            p = tw_words[n-1];
            tw_words[n] = mt64_pkg::MUL_SEED * (p ^ (p >> 62)) + 64'(n);
        end
        tw_pos = mt64_pkg::STATE_WORDS;
    endfunction

    function automatic int key_span();
        int len;
        len = shadow_klen;
        if (len == 0) len = 1;
        if (len > KEY_SLOTS) len = KEY_SLOTS;
        return len;
    endfunction

    function automatic void seed_from_keys();
        int len, i, j;
        logic [63:0] p;
        len = key_span();
        seed_words(mt64_pkg::KEY_BASE_SEED);
        i = 1;
        j = 0;
        for (int c = mt64_pkg::STATE_WORDS; c > 0; c--) begin
            p = tw_words[i-1];
            tw_words[i] = (tw_words[i] ^ ((p ^ (p >> 62)) * mt64_pkg::MUL_KEY_A))
                          + shadow_keys[j] + 64'(j);
            i++;
            j++;
            if (i >= mt64_pkg::STATE_WORDS) begin
                tw_words[0] = tw_words[mt64_pkg::STATE_WORDS-1];
                i = 1;
            end
            if (j >= len) j = 0;
        end
        for (int c = mt64_pkg::STATE_WORDS - 1; c > 0; c--) begin
            p = tw_words[i-1];
            tw_words[i] = (tw_words[i] ^ ((p ^ (p >> 62)) * mt64_pkg::MUL_KEY_B)) - 64'(i);
            i++;
            if (i >= mt64_pkg::STATE_WORDS) begin
                tw_words[0] = tw_words[mt64_pkg::STATE_WORDS-1];
                i = 1;
            end
        end
        tw_words[0] = mt64_pkg::KEY_TOP_WORD;
        tw_pos = mt64_pkg::STATE_WORDS;
    endfunction

    function automatic void twist_all();
        logic [63:0] x, v;
        for (int n = 0; n < mt64_pkg::STATE_WORDS; n++) begin
            x = (tw_words[n] & mt64_pkg::UPPER_MASK)
              | (tw_words[(n + 1) % mt64_pkg::STATE_WORDS] & mt64_pkg::LOWER_MASK);
            v = tw_words[(n + mt64_pkg::SHIFT_OFFSET) % mt64_pkg::STATE_WORDS] ^ (x >> 1);
            if (x[0]) v ^= mt64_pkg::TWIST_MATRIX;
            tw_words[n] = v;
        end
        tw_pos = 0;
    endfunction

    function automatic logic [63:0] next_tempered();
        logic [63:0] x;
        if (tw_pos >= mt64_pkg::STATE_WORDS) twist_all();
        x = tw_words[tw_pos];
        tw_pos++;
        x ^= (x >> 29) & mt64_pkg::TEMPER_U;
        x ^= (x << 17) & mt64_pkg::TEMPER_B;
        x ^= (x << 37) & mt64_pkg::TEMPER_C;
        x ^= (x >> 43);
        if (shadow_mode) x = x >> 1;
        return x;
    endfunction

    // returns 1 when the request produces a number
    function automatic bit apply_request(logic [1:0] op, logic [63:0] seed, logic [3:0] idx,
                                         logic [63:0] word, output logic [63:0] value);
        value = '0;
        case (op)
            mt64_pkg::OP_SEED: seed_words(seed);
            mt64_pkg::OP_DRAW: begin
                value = next_tempered();
                return 1;
            end
            mt64_pkg::OP_KEY_LOAD: begin
                shadow_keys[idx] = word;
                keys_written[idx] = 1'b1;
            end
            default: seed_from_keys();
        endcase
        return 0;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        error_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // output side: random stall, result check, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_values.size() == 0) begin
                report_mismatch("unexpected result", '0, o_random_value);
            end else if (pending_values[0] !== o_random_value) begin
                report_mismatch("random_value", pending_values[0], o_random_value);
                void'(pending_values.pop_front());
            end else begin
                void'(pending_values.pop_front());
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if ($urandom_range(0, 299) == 0) quiet_out = ~quiet_out;
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet_out && $urandom_range(0, 99) < 30) begin
            stall_left = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_request(logic [1:0] op, logic [63:0] seed, logic [3:0] idx,
                                logic [63:0] word, bit known, logic [63:0] known_value);
        logic [63:0] value;
        int gap;
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_seed_value <= seed;
        i_key_index  <= idx;
        i_key_word   <= word;
        do @(posedge i_clk); while (o_in_stall);
        if (apply_request(op, seed, idx, word, value)) begin
            if (known && value !== known_value) report_mismatch("predictor", known_value, value);
            pending_values.push_back(known ? known_value : value);
        end
        gap = $urandom_range(0, 99);
        if (gap < 40) gap = 0;
        else if (gap < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_register(logic [7:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == mt64_pkg::CFG_KEY_LENGTH) shadow_klen = data[4:0];
        else if (idx == mt64_pkg::CFG_OUTPUT_MODE) shadow_mode = data[0];
        @(posedge i_clk);
    endtask

    task automatic random_request();
        int r;
        logic [63:0] seed;
        logic [3:0] idx;
        bit ready_keys;
        r = $urandom_range(0, 99);
        idx = 4'($urandom_range(0, KEY_SLOTS - 1));
        ready_keys = 1;
        for (int k = 0; k < key_span(); k++) if (!keys_written[k]) ready_keys = 0;
        if (r < 3) begin
            case ($urandom_range(0, 3))
                0: seed = '0;
                1: seed = '1;
                default: seed = {$urandom, $urandom};
            endcase
            send_request(mt64_pkg::OP_SEED, seed, idx, {$urandom, $urandom}, 0, '0);
        end else if (r < 5 && ready_keys) begin
            send_request(mt64_pkg::OP_KEY_SEED, {$urandom, $urandom}, idx,
                         {$urandom, $urandom}, 0, '0);
        end else if (r < 14 || (r < 5 && !ready_keys)) begin
            if (!ready_keys) begin
                for (int k = KEY_SLOTS - 1; k >= 0; k--) if (!keys_written[k]) idx = 4'(k);
            end
            send_request(mt64_pkg::OP_KEY_LOAD, {$urandom, $urandom}, idx,
                         {$urandom, $urandom}, 0, '0);
        end else begin
            send_request(mt64_pkg::OP_DRAW, {$urandom, $urandom}, idx,
                         {$urandom, $urandom}, 0, '0);
        end
    endtask

    t_stim_row  directed_rows [0:17];
    logic [7:0] phase_klen [0:5];
    logic [7:0] phase_mode [0:5];

    initial begin
        directed_rows = '{
            '{mt64_pkg::OP_DRAW,     '0, 4'd0,  '0, 1'b1, 64'hC96D191CF6F6AEA6},
            '{mt64_pkg::OP_DRAW,     '0, 4'd0,  '0, 1'b0, '0},
            '{mt64_pkg::OP_DRAW,     '1, 4'd15, '1, 1'b0, '0},
            '{mt64_pkg::OP_SEED,     '0, 4'd0,  '0, 1'b0, '0},
            '{mt64_pkg::OP_DRAW,     '0, 4'd0,  '0, 1'b0, '0},
            '{mt64_pkg::OP_SEED,     '1, 4'd15, '1, 1'b0, '0},
            '{mt64_pkg::OP_DRAW,     '0, 4'd0,  '0, 1'b0, '0},
            '{mt64_pkg::OP_SEED,     mt64_pkg::DEFAULT_SEED, 4'd0, '0, 1'b0, '0},
            '{mt64_pkg::OP_DRAW,     '0, 4'd0,  '0, 1'b1, 64'hC96D191CF6F6AEA6},
            '{mt64_pkg::OP_KEY_LOAD, '0, 4'd0,  '0, 1'b0, '0},
            '{mt64_pkg::OP_KEY_LOAD, '0, 4'd15, '1, 1'b0, '0},
            '{mt64_pkg::OP_KEY_LOAD, '0, 4'd7,  64'h5555555555555555, 1'b0, '0},
            '{mt64_pkg::OP_KEY_LOAD, '0, 4'd0,  '1, 1'b0, '0},
            '{mt64_pkg::OP_KEY_SEED, '0, 4'd0,  '0, 1'b0, '0},
            '{mt64_pkg::OP_DRAW,     '0, 4'd0,  '0, 1'b0, '0},
            '{mt64_pkg::OP_DRAW,     '0, 4'd0,  '0, 1'b0, '0},
            '{mt64_pkg::OP_KEY_LOAD, '0, 4'd3,  64'hAAAAAAAAAAAAAAAA, 1'b0, '0},
            '{mt64_pkg::OP_DRAW,     '0, 4'd0,  '0, 1'b0, '0}
        };
        // key length zero and above the store depth are part of the sweep
        phase_klen = '{8'd16, 8'd1, 8'd0, 8'hF4, 8'd7, 8'd16};
        phase_mode = '{8'd1, 8'd0, 8'd1, 8'hFE, 8'd1, 8'd0};
        error_count  = 0;
        idle_cycles  = 0;
        stall_left   = 0;
        quiet_out    = 0;
        keys_written = '0;
        shadow_klen  = 5'd1;
        shadow_mode  = 1'b0;
        for (int k = 0; k < KEY_SLOTS; k++) shadow_keys[k] = '0;
        seed_words(mt64_pkg::DEFAULT_SEED);
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_operation  <= mt64_pkg::OP_DRAW;
        i_seed_value <= '0;
        i_key_index  <= '0;
        i_key_word   <= '0;
        i_out_stall  <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            send_request(directed_rows[n].op, directed_rows[n].seed, directed_rows[n].idx,
                         directed_rows[n].word, directed_rows[n].known,
                         directed_rows[n].known_value);
        end

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_register(mt64_pkg::CFG_KEY_LENGTH, phase_klen[ph]);
            write_register(mt64_pkg::CFG_OUTPUT_MODE, phase_mode[ph]);
            if (ph == 2) write_register(CFG_SPARE, 8'hFF);
            repeat (ITEMS_PHASE) random_request();
        end

        i_in_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
